FILE: hw/rtl/spd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the segment pair distance block.
// No dependencies.
package spd_pkg;

	localparam int COORD_W  = 32;
	localparam int ANGLE_W  = 16;
	localparam int HL_W     = 31;
	localparam int DIST_W   = 32;
	localparam int CRD_W    = COORD_W + 4;
	localparam int SIN_LAT  = 8;
	localparam int SQ_STAGES = 8;
	localparam int SQ_STEPS  = 4;
	localparam int LAT      = SIN_LAT + 8 + SQ_STAGES;

	localparam logic [HL_W-1:0] HL_RESET  = HL_W'(65536);
	localparam logic [63:0]     Q30_HALF  = 64'd536870912;

	typedef logic signed [31:0] trig_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_center_x;
		logic signed [COORD_W-1:0] first_center_y;
		logic [ANGLE_W-1:0]        first_angle;
		logic signed [COORD_W-1:0] second_center_x;
		logic signed [COORD_W-1:0] second_center_y;
		logic [ANGLE_W-1:0]        second_angle;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              crossing;
	} out_item_t;

endpackage

FILE: hw/rtl/segment_pair_distance.sv
`timescale 1ns / 1ps
// Top level: distance between two equal half-length segments, Q16.16.
// Depends on spd_pkg and spd_sine.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one segment pair per
//   transfer; output channel out_valid/out_stall/out_data returns one
//   distance and crossing flag per pair, in order.
//   cfg_valid/cfg_ready/cfg_data writes the shared half-length; cfg_ready
//   is always high. Write it only while the pipeline is empty.
//   The pipeline holds the sine polynomial, then the overlap test,
//   projections and minimum, then the 32-step square root at four steps
//   per stage. One pair can enter every cycle while no result is stalled.
//   Reset clears all valid bits and sets the half-length to 1.0.
//   When the receiver stalls a waiting result, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated.
module segment_pair_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  spd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output spd_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [spd_pkg::HL_W-1:0] cfg_data
);
	import spd_pkg::*;

	typedef logic signed [CRD_W-1:0] crd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic signed [COORD_W:0]   ox;
		logic signed [COORD_W:0]   oy;
	} pos_t;

	localparam logic [1:0] BELOW_IDX [0:3] = '{2'd0, 2'd2, 2'd0, 2'd3};
	localparam logic [1:0] ABOVE_IDX [0:3] = '{2'd3, 2'd1, 2'd2, 2'd1};
	localparam logic [1:0] PA_IDX    [0:3] = '{2'd0, 2'd1, 2'd2, 2'd3};
	localparam logic [1:0] PB_IDX    [0:3] = '{2'd2, 2'd3, 2'd1, 2'd0};
	localparam logic [CRD_W-1:0] SAT_C = CRD_W'(33'h0_FFFF_FFFF);

	function automatic logic [CRD_W-1:0] mulu(input logic [CRD_W-1:0] a,
		input logic [31:0] b);
		logic [CRD_W+31:0] p;
		p = (CRD_W+32)'(a) * (CRD_W+32)'(b) + (CRD_W+32)'(Q30_HALF);
		return p[CRD_W+29:30];
	endfunction

	function automatic logic [CRD_W-1:0] mag(input crd_t v);
		return v[CRD_W-1] ? CRD_W'(-v) : CRD_W'(v);
	endfunction

	function automatic logic [31:0] tmag(input trig_t q);
		return q[31] ? 32'(-q) : 32'(q);
	endfunction

	function automatic crd_t mulq(input crd_t v, input trig_t q);
		logic [CRD_W-1:0] m;
		m = mulu(mag(v), tmag(q));
		return (v[CRD_W-1] != q[31]) ? -crd_t'(m) : crd_t'(m);
	endfunction

	logic              ce;
	logic [HL_W-1:0]   hl_q;
	crd_t              rr;
	logic              vld_s [1:LAT];
	logic              hit_s [10:LAT];
	pos_t              dl_s  [1:SIN_LAT];
	pos_t              pin;
	logic [31:0]       t1, t2;
	trig_t             ca, sa, cb, sb, sd;

	// s9
	logic signed [COORD_W-1:0] px_s9, py_s9, qx_s9, qy_s9;
	logic signed [COORD_W:0]   ox_s9, oy_s9;
	trig_t             ca_s9, sa_s9, cb_s9, sb_s9;
	logic [CRD_W-1:0]  boxx_s9, boxy_s9, lim_s9;
	crd_t              o1a_s9, o1b_s9, o2a_s9, o2b_s9;
	crd_t              h1x_s9, h1y_s9, h2x_s9, h2y_s9;
	// s10
	logic signed [COORD_W-1:0] px_s10, py_s10, qx_s10, qy_s10;
	trig_t             ca_s10, sa_s10, cb_s10, sb_s10;
	crd_t              epx_s10 [0:3];
	crd_t              epy_s10 [0:3];
	// s11
	trig_t             ca_s11, sa_s11, cb_s11, sb_s11;
	crd_t              vx_s11 [0:3];
	crd_t              vy_s11 [0:3];
	logic [31:0]       gx_s11 [0:3];
	logic [31:0]       gy_s11 [0:3];
	logic              gsat_s11 [0:3];
	// s12
	crd_t              al1_s12 [0:3];
	crd_t              al2_s12 [0:3];
	crd_t              pp1_s12 [0:3];
	crd_t              pp2_s12 [0:3];
	logic [63:0]       sx_s12 [0:3];
	logic [63:0]       sy_s12 [0:3];
	logic              gsat_s12 [0:3];
	// s13, s14
	logic              below_s13 [0:3];
	logic              above_s13 [0:3];
	logic [31:0]       perp_s13 [0:3];
	logic [63:0]       pkey_s13 [0:3];
	logic              below_s14 [0:3];
	logic              above_s14 [0:3];
	logic [63:0]       psq_s14 [0:3];
	logic [63:0]       pkey_s14 [0:3];
	// s15.. square root
	logic [63:0]       mn_s15 [0:1];
	logic [63:0]       sqn_s [16:LAT];
	logic [63:0]       sqr_s [16:LAT];
	logic [63:0]       sqn_d [0:SQ_STAGES-1];
	logic [63:0]       sqr_d [0:SQ_STAGES-1];
	logic [63:0]       key [0:3];

	assign ce        = !(vld_s[LAT] && out_stall);
	assign in_stall  = !ce;
	assign cfg_ready = 1'b1;
	assign rr        = crd_t'({{(CRD_W-HL_W){1'b0}}, hl_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= HL_RESET;
		end else if (cfg_valid) begin
			hl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else if (ce) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	assign t1 = 32'(in_data.first_angle) << (32 - ANGLE_W);
	assign t2 = 32'(in_data.second_angle) << (32 - ANGLE_W);

	spd_sine u_sa (.clk(clk), .ce(ce), .turn(t1), .sin_val(sa));
	spd_sine u_ca (.clk(clk), .ce(ce), .turn(t1 + 32'h4000_0000), .sin_val(ca));
	spd_sine u_sb (.clk(clk), .ce(ce), .turn(t2), .sin_val(sb));
	spd_sine u_cb (.clk(clk), .ce(ce), .turn(t2 + 32'h4000_0000), .sin_val(cb));
	spd_sine u_sd (.clk(clk), .ce(ce), .turn(t1 - t2), .sin_val(sd));

	always_comb begin
		pin.px = in_data.first_center_x;
		pin.py = in_data.first_center_y;
		pin.qx = in_data.second_center_x;
		pin.qy = in_data.second_center_y;
		pin.ox = (COORD_W+1)'(in_data.first_center_x) - (COORD_W+1)'(in_data.second_center_x);
		pin.oy = (COORD_W+1)'(in_data.first_center_y) - (COORD_W+1)'(in_data.second_center_y);
	end

	// pick keys: squared point distances or squared perpendiculars
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (below_s14[k]) key[k] = pkey_s14[BELOW_IDX[k]];
			else if (above_s14[k]) key[k] = pkey_s14[ABOVE_IDX[k]];
			else key[k] = psq_s14[k];
		end
	end

	always_comb begin : sq_step
		logic [63:0] n, r, b;
		for (int j = 0; j < SQ_STAGES; j++) begin
			n = sqn_s[16+j];
			r = sqr_s[16+j];
			for (int k = 0; k < SQ_STEPS; k++) begin
				b = 64'd1 << (62 - 2 * (SQ_STEPS * j + k));
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			sqn_d[j] = n;
			sqr_d[j] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dl_s[1] <= pin;
			for (int i = 2; i <= SIN_LAT; i++) dl_s[i] <= dl_s[i-1];

			// s9: overlap products and half-vectors
			px_s9 <= dl_s[SIN_LAT].px;
			py_s9 <= dl_s[SIN_LAT].py;
			qx_s9 <= dl_s[SIN_LAT].qx;
			qy_s9 <= dl_s[SIN_LAT].qy;
			ox_s9 <= dl_s[SIN_LAT].ox;
			oy_s9 <= dl_s[SIN_LAT].oy;
			ca_s9 <= ca;
			sa_s9 <= sa;
			cb_s9 <= cb;
			sb_s9 <= sb;
			boxx_s9 <= mulu(CRD_W'(hl_q), tmag(ca) + tmag(cb));
			boxy_s9 <= mulu(CRD_W'(hl_q), tmag(sa) + tmag(sb));
			lim_s9  <= mulu(CRD_W'(hl_q), tmag(sd));
			o1a_s9 <= mulq(crd_t'(dl_s[SIN_LAT].ox), sa);
			o1b_s9 <= mulq(crd_t'(dl_s[SIN_LAT].oy), ca);
			o2a_s9 <= mulq(crd_t'(dl_s[SIN_LAT].ox), sb);
			o2b_s9 <= mulq(crd_t'(dl_s[SIN_LAT].oy), cb);
			h1x_s9 <= mulq(rr, ca);
			h1y_s9 <= mulq(rr, sa);
			h2x_s9 <= mulq(rr, cb);
			h2y_s9 <= mulq(rr, sb);

			// s10: overlap decision, endpoints a, b, c, d
			hit_s[10] <= (mag(crd_t'(ox_s9)) < boxx_s9) && (mag(crd_t'(oy_s9)) < boxy_s9) &&
				((mag(o1a_s9 - o1b_s9) <= lim_s9) || (mag(o2a_s9 - o2b_s9) <= lim_s9));
			epx_s10[0] <= crd_t'(px_s9) - h1x_s9;
			epy_s10[0] <= crd_t'(py_s9) - h1y_s9;
			epx_s10[1] <= crd_t'(px_s9) + h1x_s9;
			epy_s10[1] <= crd_t'(py_s9) + h1y_s9;
			epx_s10[2] <= crd_t'(qx_s9) - h2x_s9;
			epy_s10[2] <= crd_t'(qy_s9) - h2y_s9;
			epx_s10[3] <= crd_t'(qx_s9) + h2x_s9;
			epy_s10[3] <= crd_t'(qy_s9) + h2y_s9;
			px_s10 <= px_s9;
			py_s10 <= py_s9;
			qx_s10 <= qx_s9;
			qy_s10 <= qy_s9;
			ca_s10 <= ca_s9;
			sa_s10 <= sa_s9;
			cb_s10 <= cb_s9;
			sb_s10 <= sb_s9;

			// s11: offsets to the other center, endpoint pair gaps
			for (int k = 0; k < 4; k++) begin
				vx_s11[k] <= epx_s10[k] - ((k < 2) ? crd_t'(qx_s10) : crd_t'(px_s10));
				vy_s11[k] <= epy_s10[k] - ((k < 2) ? crd_t'(qy_s10) : crd_t'(py_s10));
				gx_s11[k] <= 32'(mag(epx_s10[PA_IDX[k]] - epx_s10[PB_IDX[k]]));
				gy_s11[k] <= 32'(mag(epy_s10[PA_IDX[k]] - epy_s10[PB_IDX[k]]));
				gsat_s11[k] <= (mag(epx_s10[PA_IDX[k]] - epx_s10[PB_IDX[k]]) > SAT_C) ||
					(mag(epy_s10[PA_IDX[k]] - epy_s10[PB_IDX[k]]) > SAT_C);
			end
			ca_s11 <= ca_s10;
			sa_s11 <= sa_s10;
			cb_s11 <= cb_s10;
			sb_s11 <= sb_s10;

			// s12: projections and squares
			for (int k = 0; k < 4; k++) begin
				al1_s12[k] <= mulq(vx_s11[k], (k < 2) ? cb_s11 : ca_s11);
				al2_s12[k] <= mulq(vy_s11[k], (k < 2) ? sb_s11 : sa_s11);
				pp1_s12[k] <= mulq(vx_s11[k], (k < 2) ? sb_s11 : sa_s11);
				pp2_s12[k] <= mulq(vy_s11[k], (k < 2) ? cb_s11 : ca_s11);
				sx_s12[k]  <= 64'(gx_s11[k]) * 64'(gx_s11[k]);
				sy_s12[k]  <= 64'(gy_s11[k]) * 64'(gy_s11[k]);
				gsat_s12[k] <= gsat_s11[k];
			end

			// s13: range decision, perpendicular, point keys
			for (int k = 0; k < 4; k++) begin
				below_s13[k] <= (al1_s12[k] + al2_s12[k]) < -rr;
				above_s13[k] <= (al1_s12[k] + al2_s12[k]) > rr;
				perp_s13[k]  <= (mag(pp1_s12[k] - pp2_s12[k]) > SAT_C) ? 32'hFFFF_FFFF :
					32'(mag(pp1_s12[k] - pp2_s12[k]));
				pkey_s13[k]  <= (gsat_s12[k] || ((65'(sx_s12[k]) + 65'(sy_s12[k])) >> 64) != 65'd0)
					? 64'hFFFF_FFFF_FFFF_FFFF : (sx_s12[k] + sy_s12[k]);
			end

			// s14: perpendicular squared
			for (int k = 0; k < 4; k++) begin
				psq_s14[k]   <= 64'(perp_s13[k]) * 64'(perp_s13[k]);
				below_s14[k] <= below_s13[k];
				above_s14[k] <= above_s13[k];
				pkey_s14[k]  <= pkey_s13[k];
			end

			// s15, s16: minimum
			mn_s15[0] <= (key[1] < key[0]) ? key[1] : key[0];
			mn_s15[1] <= (key[3] < key[2]) ? key[3] : key[2];
			sqn_s[16] <= (mn_s15[1] < mn_s15[0]) ? mn_s15[1] : mn_s15[0];
			sqr_s[16] <= 64'd0;

			for (int j = 0; j < SQ_STAGES; j++) begin
				sqn_s[17+j] <= sqn_d[j];
				sqr_s[17+j] <= sqr_d[j];
			end

			for (int i = 11; i <= LAT; i++) hit_s[i] <= hit_s[i-1];
		end
	end

	assign out_valid         = vld_s[LAT];
	assign out_data.crossing = hit_s[LAT];
	assign out_data.distance = hit_s[LAT] ? '0 : sqr_s[LAT][DIST_W-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAT] && out_stall) |=> (vld_s[LAT] && $stable(sqr_s[LAT]) && $stable(hit_s[LAT])))
		else $error("pipeline moved while result stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[1])
		else $error("accepted transfer not in first stage");

	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT] |-> !sqr_s[LAT][32])
		else $error("square root exceeds 32 bits");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[10] && hl_q == '0) |-> !hit_s[10])
		else $error("crossing reported with zero half-length");

endmodule

FILE: hw/rtl/spd_sine.sv
`timescale 1ns / 1ps
// Pipelined sine of a 32-bit turn fraction, Q2.30 out, eight register stages.
// Depends on spd_pkg.
module spd_sine (
	input  logic          clk,
	input  logic          ce,
	input  logic [31:0]   turn,
	output spd_pkg::trig_t sin_val
);
	import spd_pkg::*;

	localparam logic [31:0] SK11 = 32'd3864;
	localparam logic [31:0] KTAB [0:4] = '{32'd172272, 32'd5026991, 32'd85569306,
		32'd693598668, 32'd1686629713};

	function automatic logic [31:0] horner(input logic [31:0] k, input logic [30:0] t,
		input logic [31:0] a);
		logic [63:0] p;
		p = 64'(t) * 64'(a) + Q30_HALF;
		return k - p[61:30];
	endfunction

	logic [30:0] z_s   [0:6];
	logic [30:0] t_s   [1:6];
	logic [31:0] acc_s [1:6];
	logic        neg_s [0:6];
	trig_t       sin_s8;
	logic [30:0] z_in;
	logic [63:0] pz;
	logic [63:0] pr;
	logic [32:0] res;
	logic [30:0] res_c;

	assign z_in = turn[30] ? (31'h4000_0000 - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
	assign pz   = 64'(z_s[0]) * 64'(z_s[0]) + Q30_HALF;
	assign pr   = 64'(z_s[6]) * 64'(acc_s[6]) + Q30_HALF;
	assign res  = pr[62:30];
	assign res_c = (res > 33'h4000_0000) ? 31'h4000_0000 : res[30:0];

	always_ff @(posedge clk) begin
		if (ce) begin
			z_s[0]   <= z_in;
			neg_s[0] <= turn[31];
			z_s[1]   <= z_s[0];
			neg_s[1] <= neg_s[0];
			t_s[1]   <= pz[60:30];
			acc_s[1] <= SK11;
			for (int i = 2; i <= 6; i++) begin
				z_s[i]   <= z_s[i-1];
				neg_s[i] <= neg_s[i-1];
				t_s[i]   <= t_s[i-1];
				acc_s[i] <= horner(KTAB[i-2], t_s[i-1], acc_s[i-1]);
			end
			sin_s8 <= neg_s[6] ? -trig_t'({1'b0, res_c}) : trig_t'({1'b0, res_c});
		end
	end

	assign sin_val = sin_s8;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for segment_pair_distance: random and directed segment pairs
// checked against an in-bench fixed-point predictor. Depends on spd_pkg.
module tb;
	import spd_pkg::*;

	localparam logic [63:0] SAT32 = 64'hFFFFFFFF;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_item_t in_data;
	out_item_t out_data;
	logic [HL_W-1:0] cfg_data;

	in_item_t pair_q[$];
	out_item_t dist_q[$];
	logic [HL_W-1:0] r_cur;
	int errors, in_idle_pct, out_stall_pct;
	bit hold_in;
	logic in_took;
	bit send_now;

	segment_pair_distance uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] mag(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] mulfix(logic [63:0] a, logic [63:0] b);
		return (a >> 32) * b * 4 + (((a & SAT32) * b + Q30_HALF) >> 30);
	endfunction

	function automatic logic signed [63:0] mulq(logic signed [63:0] v, q);
		logic [63:0] m;
		m = mulfix(mag(v), mag(q));
		return ((v < 0) != (q < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] sine(logic [31:0] a);
		logic [63:0] f, t, acc, res;
		logic [63:0] k[5];
		k = '{64'd172272, 64'd5026991, 64'd85569306, 64'd693598668, 64'd1686629713};
		f = a[29:0];
		if (a[30]) f = Q30_ONE - f;
		t = (f * f + Q30_HALF) >> 30;
		acc = 64'd3864;
		for (int i = 0; i < 5; i++) acc = k[i] - ((t * acc + Q30_HALF) >> 30);
		res = (f * acc + Q30_HALF) >> 30;
		if (res > Q30_ONE) res = Q30_ONE;
		return a[31] ? -$signed(res) : $signed(res);
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] point_gap(logic signed [63:0] ax, ay, bx, by);
		logic [63:0] gx, gy, sx, sy;
		gx = mag(ax - bx);
		gy = mag(ay - by);
		if (gx > SAT32 || gy > SAT32) return SAT32;
		sx = gx * gx;
		sy = gy * gy;
		if (sx > ~sy) return SAT32;
		return isqrt(sx + sy);
	endfunction

	function automatic logic [63:0] end_gap(logic signed [63:0] px, py, cx, cy, co, si,
			rr, logic [63:0] lo, hi);
		logic signed [63:0] vx, vy, al;
		logic [63:0] pp;
		vx = px - cx;
		vy = py - cy;
		al = mulq(vx, co) + mulq(vy, si);
		if (al < -rr) return lo;
		if (al > rr) return hi;
		pp = mag(mulq(vx, si) - mulq(vy, co));
		return pp > SAT32 ? SAT32 : pp;
	endfunction

	function automatic out_item_t pair_distance(in_item_t it, logic [HL_W-1:0] r);
		logic signed [63:0] px, py, qx, qy, ca, sa, cb, sb, ox, oy, rr;
		logic signed [63:0] hx1, hy1, hx2, hy2, axp, ayp, bxp, byp, cxp, cyp, dxp, dyp;
		logic [63:0] hl, lim, gac, gbd, gcb, gda, best, g;
		logic [31:0] a1, a2;
		out_item_t o;
		px = it.first_center_x; py = it.first_center_y;
		qx = it.second_center_x; qy = it.second_center_y;
		a1 = {it.first_angle, 16'd0};
		a2 = {it.second_angle, 16'd0};
		hl = r;
		rr = $signed(hl);
		ca = sine(a1 + 32'h40000000); sa = sine(a1);
		cb = sine(a2 + 32'h40000000); sb = sine(a2);
		ox = px - qx; oy = py - qy;
		o.crossing = 0;
		if (mag(ox) < mulfix(hl, mag(ca) + mag(cb)) &&
				mag(oy) < mulfix(hl, mag(sa) + mag(sb))) begin
			lim = mulfix(hl, mag(sine(a1 - a2)));
			o.crossing = (mag(mulq(ox, sa) - mulq(oy, ca)) <= lim) ||
				(mag(mulq(ox, sb) - mulq(oy, cb)) <= lim);
		end
		best = 0;
		if (!o.crossing) begin
			hx1 = mulq(rr, ca); hy1 = mulq(rr, sa);
			hx2 = mulq(rr, cb); hy2 = mulq(rr, sb);
			axp = px - hx1; ayp = py - hy1; bxp = px + hx1; byp = py + hy1;
			cxp = qx - hx2; cyp = qy - hy2; dxp = qx + hx2; dyp = qy + hy2;
			gac = point_gap(axp, ayp, cxp, cyp);
			gbd = point_gap(bxp, byp, dxp, dyp);
			gcb = point_gap(cxp, cyp, bxp, byp);
			gda = point_gap(dxp, dyp, axp, ayp);
			best = end_gap(axp, ayp, qx, qy, cb, sb, rr, gac, gda);
			g = end_gap(bxp, byp, qx, qy, cb, sb, rr, gcb, gbd);
			if (g < best) best = g;
			g = end_gap(cxp, cyp, px, py, ca, sa, rr, gac, gcb);
			if (g < best) best = g;
			g = end_gap(dxp, dyp, px, py, ca, sa, rr, gda, gbd);
			if (g < best) best = g;
		end
		o.distance = best[31:0];
		return o;
	endfunction

	task automatic report(string what, out_item_t got, out_item_t want);
		$display("mismatch %s: got %h/%b want %h/%b", what, got.distance, got.crossing,
			want.distance, want.crossing);
		errors++;
	endtask

	// input transfer seen at the rising edge
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) begin
				dist_q.push_back(pair_distance(in_data, r_cur));
				void'(pair_q.pop_front());
			end
			if (!in_valid || in_took) begin
				send_now = pair_q.size() > 0 && !hold_in && $urandom_range(99) >= in_idle_pct;
				in_valid <= send_now;
				if (send_now) in_data <= pair_q[0];
			end
			out_stall <= $urandom_range(99) < out_stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (dist_q.size() == 0) report("unexpected", out_data, '0);
			else begin
				if (out_data.distance !== dist_q[0].distance ||
						out_data.crossing !== dist_q[0].crossing)
					report("field", out_data, dist_q[0]);
				void'(dist_q.pop_front());
			end
		end
	end

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
			default: return $signed($urandom_range(0, 32'h6000000)) - 32'sh3000000;
		endcase
	endfunction

	function automatic in_item_t rnd_pair();
		in_item_t it;
		int m;
		m = $urandom_range(2);
		it.first_center_x = rnd_coord(m);
		it.first_center_y = rnd_coord(m);
		it.second_center_x = rnd_coord(m);
		it.second_center_y = rnd_coord(m);
		it.first_angle = ANGLE_W'($urandom);
		it.second_angle = ANGLE_W'($urandom);
		return it;
	endfunction

	task automatic drain();
		while (pair_q.size() > 0 || in_valid || dist_q.size() > 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	task automatic set_length(logic [HL_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		r_cur = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		in_item_t it;
		logic [HL_W-1:0] lens[6];
		lens = '{31'd65536, 31'd0, 31'd1, 31'h7FFFFFFF, 31'd200000, 31'h01000000};
		arst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0; cfg_data = 0;
		in_data = '0; errors = 0; in_idle_pct = 0; out_stall_pct = 0; hold_in = 0;
		r_cur = HL_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1;
		// directed: extremes, identical centers, far apart
		it = '0; pair_q.push_back(it);
		it.second_angle = 16'h4000; pair_q.push_back(it);
		it = '{32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 32'h80000000, 32'h80000000, 16'h0};
		pair_q.push_back(it);
		it = '{32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h7FFFFFFF, 32'h80000000, 16'hC000};
		pair_q.push_back(it);
		it = '{32'h00010000, 32'h0, 16'h4000, 32'hFFFF0000, 32'h0, 16'h4000};
		pair_q.push_back(it);
		it = '{32'h00020000, 32'h0, 16'h0, 32'h0, 32'h0, 16'h0};
		pair_q.push_back(it);
		it = '{32'h00008000, 32'h00008000, 16'h2000, 32'h0, 32'h0, 16'h6000};
		pair_q.push_back(it);
		drain();
		foreach (lens[i]) begin
			set_length(lens[i]);
			for (int p = 0; p < 4; p++) begin
				in_idle_pct = (p == 1 || p == 3) ? (p == 3 ? 34 : 50) : 0;
				out_stall_pct = (p == 2) ? 50 : (p == 3 ? 34 : 0);
				for (int n = 0; n < 36; n++) pair_q.push_back(rnd_pair());
				if (p == 1) begin
					while (pair_q.size() > 20) @(posedge clk);
					hold_in = 1;
					while (in_valid || dist_q.size() > 0) @(posedge clk);
					hold_in = 0;
				end
				drain();
			end
		end
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
